// File: rtl/dsrpg_pkg.sv
// Package with the types and constants shared by the dual stepper step generator.
`default_nettype none
package dsrpg_pkg;

  localparam int unsigned TickFreqW = 20;
  localparam int unsigned RateMagW  = 15;
  localparam int unsigned RateW     = 16;
  localparam int unsigned PhaseW    = 21;
  localparam int unsigned PosW      = 32;
  localparam int unsigned CfgIdxW   = 2;
  localparam int unsigned CfgDataW  = 20;

  localparam logic [TickFreqW-1:0] TickFreqReset = 20'd20000;
  localparam logic [RateMagW-1:0]  MaxRateReset  = 15'd3200;

  typedef enum logic [1:0] {
    ACT_TICK      = 2'd0,
    ACT_SET_RATES = 2'd1,
    ACT_STOP      = 2'd2,
    ACT_CLEAR_POS = 2'd3
  } action_t;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_TICK_FREQUENCY = 2'd0,
    CFG_MAX_RATE       = 2'd1,
    CFG_INVERT_LEFT    = 2'd2,
    CFG_INVERT_RIGHT   = 2'd3
  } cfg_index_t;

  typedef struct packed {
    action_t                  action;
    logic signed [RateW-1:0]  rate_left;
    logic signed [RateW-1:0]  rate_right;
  } in_item_t;

  typedef struct packed {
    logic                     step_left;
    logic                     step_right;
    logic                     dir_left;
    logic                     dir_right;
    logic signed [PosW-1:0]   position_left;
    logic signed [PosW-1:0]   position_right;
  } out_item_t;

endpackage
`default_nettype wire

// File: rtl/dual_stepper_rate_pulse_generator.sv
// Top level of the dual stepper step generator with phase accumulators.
// Each result is registered when its item is accepted.
// Throughput: one item per cycle while each result is taken; the path is one add, compare and subtract per motor.
// The input side stays ready while a finished result waits if that result is taken.
// Synchronous active-low reset sets the default registers, zero rates, phases
// and positions, and forward directions; no result is pending after reset.
`default_nettype none
module dual_stepper_rate_pulse_generator (
  input  wire                                  clk,
  input  wire                                  rst_n,
  input  wire                                  in_valid,
  output logic                                 in_ready,
  input  dsrpg_pkg::in_item_t                  in_data,
  output logic                                 out_valid,
  input  wire                                  out_ready,
  output dsrpg_pkg::out_item_t                 out_data,
  input  wire                                  cfg_valid,
  output logic                                 cfg_ready,
  input  wire [dsrpg_pkg::CfgIdxW-1:0]         cfg_index,
  input  wire [dsrpg_pkg::CfgDataW-1:0]        cfg_data
);
  import dsrpg_pkg::*;

  typedef struct packed {
    logic [PhaseW-1:0] phase;
    logic              pulse;
  } tick_res_t;

  typedef struct packed {
    logic [RateMagW-1:0] mag;
    logic                fwd;
  } rate_res_t;

  logic [TickFreqW-1:0] tick_freq_r;
  logic [RateMagW-1:0]  max_rate_r;
  logic                 inv_left_r;
  logic                 inv_right_r;

  logic [PhaseW-1:0]    phase_left_r, phase_left_nxt;
  logic [PhaseW-1:0]    phase_right_r, phase_right_nxt;
  logic [RateMagW-1:0]  mag_left_r, mag_left_nxt;
  logic [RateMagW-1:0]  mag_right_r, mag_right_nxt;
  logic                 fwd_left_r, fwd_left_nxt;
  logic                 fwd_right_r, fwd_right_nxt;
  logic [PosW-1:0]      count_left_r, count_left_nxt;
  logic [PosW-1:0]      count_right_r, count_right_nxt;

  logic                 out_valid_r;
  out_item_t            out_data_r, out_data_nxt;

  logic [TickFreqW-1:0] thr;
  logic [TickFreqW-1:0] thr_m1;
  logic                 in_acc;
  logic                 cfg_acc;
  tick_res_t            tick_left, tick_right;
  rate_res_t            rate_left, rate_right;

  function automatic logic [RateMagW-1:0] clamp_mag(input logic [TickFreqW-1:0] lim,
                                                     input logic [RateMagW-1:0] m);
    logic [RateMagW-1:0] res;
    if (lim < {{(TickFreqW-RateMagW){1'b0}}, m}) begin
      res = lim[RateMagW-1:0];
    end else begin
      res = m;
    end
    return res;
  endfunction

  function automatic tick_res_t tick_calc(input logic [PhaseW-1:0] phase,
                                          input logic [RateMagW-1:0] mag,
                                          input logic [TickFreqW-1:0] t,
                                          input logic [TickFreqW-1:0] t_m1);
    tick_res_t           res;
    logic [PhaseW:0]     sum;
    logic [PhaseW:0]     t_ext;
    logic [RateMagW-1:0] add;
    add   = clamp_mag(t_m1, mag);
    sum   = {1'b0, phase} + {{(PhaseW+1-RateMagW){1'b0}}, add};
    t_ext = {{(PhaseW+1-TickFreqW){1'b0}}, t};
    if (sum >= t_ext) begin
      sum       = sum - t_ext;
      res.pulse = 1'b1;
    end else begin
      res.pulse = 1'b0;
    end
    res.phase = sum[PhaseW-1:0];
    return res;
  endfunction

  function automatic rate_res_t rate_calc(input logic [RateW-1:0] v,
                                          input logic [RateMagW-1:0] max_r,
                                          input logic [TickFreqW-1:0] t_m1);
    rate_res_t           res;
    logic [RateW-1:0]    mag_full;
    logic [RateMagW-1:0] m;
    logic                neg;
    neg      = v[RateW-1];
    mag_full = neg ? (~v + 1'b1) : v;
    if ({1'b0, max_r} < mag_full) begin
      m = max_r;
    end else begin
      m = mag_full[RateMagW-1:0];
    end
    res.mag = clamp_mag(t_m1, m);
    res.fwd = !neg || (max_r == '0);
    return res;
  endfunction

  assign thr       = (tick_freq_r == '0) ? {{(TickFreqW-1){1'b0}}, 1'b1} : tick_freq_r;
  assign thr_m1    = thr - 1'b1;
  assign in_ready  = rst_n && (!out_valid_r || out_ready);
  assign in_acc    = in_valid && in_ready;
  assign cfg_ready = rst_n;
  assign cfg_acc   = cfg_valid && cfg_ready;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  assign tick_left  = tick_calc(phase_left_r, mag_left_r, thr, thr_m1);
  assign tick_right = tick_calc(phase_right_r, mag_right_r, thr, thr_m1);
  assign rate_left  = rate_calc(in_data.rate_left, max_rate_r, thr_m1);
  assign rate_right = rate_calc(in_data.rate_right, max_rate_r, thr_m1);

  always_comb begin
    phase_left_nxt  = phase_left_r;
    phase_right_nxt = phase_right_r;
    mag_left_nxt    = mag_left_r;
    mag_right_nxt   = mag_right_r;
    fwd_left_nxt    = fwd_left_r;
    fwd_right_nxt   = fwd_right_r;
    count_left_nxt  = count_left_r;
    count_right_nxt = count_right_r;
    out_data_nxt.step_left  = 1'b0;
    out_data_nxt.step_right = 1'b0;
    case (in_data.action)
      ACT_TICK: begin
        phase_left_nxt  = tick_left.phase;
        phase_right_nxt = tick_right.phase;
        out_data_nxt.step_left  = tick_left.pulse;
        out_data_nxt.step_right = tick_right.pulse;
        if (tick_left.pulse) begin
          count_left_nxt = fwd_left_r ? count_left_r + 1'b1 : count_left_r - 1'b1;
        end
        if (tick_right.pulse) begin
          count_right_nxt = fwd_right_r ? count_right_r + 1'b1 : count_right_r - 1'b1;
        end
      end
      ACT_SET_RATES: begin
        mag_left_nxt  = rate_left.mag;
        fwd_left_nxt  = rate_left.fwd;
        mag_right_nxt = rate_right.mag;
        fwd_right_nxt = rate_right.fwd;
      end
      ACT_STOP: begin
        mag_left_nxt    = '0;
        mag_right_nxt   = '0;
        phase_left_nxt  = '0;
        phase_right_nxt = '0;
      end
      ACT_CLEAR_POS: begin
        count_left_nxt  = '0;
        count_right_nxt = '0;
      end
      default: begin
        count_left_nxt  = count_left_r;
      end
    endcase
    out_data_nxt.dir_left       = fwd_left_nxt ^ inv_left_r;
    out_data_nxt.dir_right      = fwd_right_nxt ^ inv_right_r;
    out_data_nxt.position_left  = count_left_nxt;
    out_data_nxt.position_right = count_right_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tick_freq_r <= TickFreqReset;
      max_rate_r  <= MaxRateReset;
      inv_left_r  <= 1'b0;
      inv_right_r <= 1'b0;
    end else if (cfg_acc) begin
      case (cfg_index_t'(cfg_index))
        CFG_TICK_FREQUENCY: tick_freq_r <= cfg_data[TickFreqW-1:0];
        CFG_MAX_RATE:       max_rate_r  <= cfg_data[RateMagW-1:0];
        CFG_INVERT_LEFT:    inv_left_r  <= cfg_data[0];
        CFG_INVERT_RIGHT:   inv_right_r <= cfg_data[0];
        default:            tick_freq_r <= tick_freq_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_left_r  <= '0;
      phase_right_r <= '0;
      mag_left_r    <= '0;
      mag_right_r   <= '0;
      fwd_left_r    <= 1'b1;
      fwd_right_r   <= 1'b1;
      count_left_r  <= '0;
      count_right_r <= '0;
    end else if (in_acc) begin
      phase_left_r  <= phase_left_nxt;
      phase_right_r <= phase_right_nxt;
      mag_left_r    <= mag_left_nxt;
      mag_right_r   <= mag_right_nxt;
      fwd_left_r    <= fwd_left_nxt;
      fwd_right_r   <= fwd_right_nxt;
      count_left_r  <= count_left_nxt;
      count_right_r <= count_right_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_acc) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      out_data_r <= out_data_nxt;
    end
  end

`ifndef ASSERT_OFF
  a_no_step_off_tick: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && in_data.action != ACT_TICK) |=> (!out_data.step_left && !out_data.step_right))
    else $error("Step pulse reported for an item that is not a tick.");

  a_stop_clears_phase: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && in_data.action == ACT_STOP) |=> (phase_left_r == '0 && phase_right_r == '0))
    else $error("Phase accumulators not cleared by a stop item.");

  a_step_moves_left: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && in_data.action == ACT_TICK)
      |=> (out_data.step_left == (count_left_r != $past(count_left_r))))
    else $error("Left position change does not match the left step pulse.");

  a_step_moves_right: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && in_data.action == ACT_TICK)
      |=> (out_data.step_right == (count_right_r != $past(count_right_r))))
    else $error("Right position change does not match the right step pulse.");
`endif

endmodule
`default_nettype wire

// File: test/testbench.sv
// Self-checking testbench for the dual stepper step generator with a scoreboard class.
`timescale 1ns / 100ps
module testbench;
  import dsrpg_pkg::*;

  class step_scoreboard;
    logic [TickFreqW-1:0] tick_freq;
    logic [RateMagW-1:0]  max_rate;
    logic                 invert[2];
    logic [PhaseW-1:0]    phase[2];
    logic [RateMagW-1:0]  mag[2];
    logic                 fwd[2];
    logic [PosW-1:0]      pos[2];
    out_item_t            expected_q[$];
    int                   errors;

    function new();
      tick_freq = TickFreqReset;
      max_rate  = MaxRateReset;
      for (int ch = 0; ch < 2; ch++) begin
        invert[ch] = 1'b0;
        phase[ch]  = '0;
        mag[ch]    = '0;
        fwd[ch]    = 1'b1;
        pos[ch]    = '0;
      end
      errors = 0;
    endfunction

    function logic [PhaseW-1:0] thresh();
      return (tick_freq == 0) ? 21'd1 : {1'b0, tick_freq};
    endfunction

    function void set_register(cfg_index_t idx, logic [CfgDataW-1:0] data);
      case (idx)
        CFG_TICK_FREQUENCY: tick_freq = data[TickFreqW-1:0];
        CFG_MAX_RATE:       max_rate = data[RateMagW-1:0];
        CFG_INVERT_LEFT:    invert[0] = data[0];
        CFG_INVERT_RIGHT:   invert[1] = data[0];
        default: ;
      endcase
    endfunction

    function void load_rate(int ch, logic signed [RateW-1:0] rate);
      logic [16:0]       m;
      logic [PhaseW-1:0] lim;
      m = rate[15] ? 17'h10000 - {1'b0, rate} : {1'b0, rate};
      if (m > {2'b00, max_rate}) m = {2'b00, max_rate};
      lim = thresh() - 21'd1;
      if (m > lim) m = lim[16:0];
      mag[ch] = m[RateMagW-1:0];
      fwd[ch] = !rate[15] || (max_rate == 0);
    endfunction

    function logic advance(int ch);
      logic [PhaseW-1:0] thr;
      logic [PhaseW-1:0] add;
      logic [PhaseW:0]   sum;
      logic              hit;
      thr = thresh();
      add = {{(PhaseW-RateMagW){1'b0}}, mag[ch]};
      if (add > thr - 21'd1) add = thr - 21'd1;
      sum = phase[ch] + add;
      hit = 1'b0;
      if (sum >= thr) begin
        sum = sum - thr;
        hit = 1'b1;
        pos[ch] = fwd[ch] ? pos[ch] + 1 : pos[ch] - 1;
      end
      phase[ch] = sum[PhaseW-1:0];
      return hit;
    endfunction

    function void note_input(in_item_t it);
      out_item_t r;
      r = '0;
      case (it.action)
        ACT_TICK: begin
          r.step_left  = advance(0);
          r.step_right = advance(1);
        end
        ACT_SET_RATES: begin
          load_rate(0, it.rate_left);
          load_rate(1, it.rate_right);
        end
        ACT_STOP: begin
          for (int ch = 0; ch < 2; ch++) begin
            mag[ch]   = '0;
            phase[ch] = '0;
          end
        end
        ACT_CLEAR_POS: begin
          pos[0] = '0;
          pos[1] = '0;
        end
        default: ;
      endcase
      r.dir_left       = fwd[0] ^ invert[0];
      r.dir_right      = fwd[1] ^ invert[1];
      r.position_left  = pos[0];
      r.position_right = pos[1];
      expected_q.push_back(r);
    endfunction

    function void check_result(out_item_t got);
      out_item_t e;
      if (expected_q.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result item at %0t", $realtime);
        return;
      end
      e = expected_q.pop_front();
      if (got.step_left !== e.step_left || got.step_right !== e.step_right ||
          got.dir_left !== e.dir_left || got.dir_right !== e.dir_right ||
          got.position_left !== e.position_left ||
          got.position_right !== e.position_right) begin
        errors++;
        if (errors <= 10)
          $display("mismatch at %0t: expected step %b/%b dir %b/%b pos %0d/%0d, %s",
                   $realtime, e.step_left, e.step_right, e.dir_left, e.dir_right,
                   e.position_left, e.position_right,
                   $sformatf("got step %b/%b dir %b/%b pos %0d/%0d",
                             got.step_left, got.step_right, got.dir_left, got.dir_right,
                             got.position_left, got.position_right));
      end
    endfunction

    function int pending();
      return expected_q.size();
    endfunction
  endclass

  logic                  clk;
  logic                  rst_n;
  logic                  in_valid;
  logic                  in_ready;
  in_item_t              in_data;
  logic                  out_valid;
  logic                  out_ready;
  out_item_t             out_data;
  logic                  cfg_valid;
  logic                  cfg_ready;
  cfg_index_t            cfg_index;
  logic [CfgDataW-1:0]   cfg_data;

  step_scoreboard sb = new();
  bit tx_burst;
  bit rx_burst;
  bit hold_request;

  dual_stepper_rate_pulse_generator dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  function automatic bit urandom_toggle();
    return $urandom_range(0, 31) == 0;
  endfunction

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("TEST FAILED");
    $finish;
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && out_ready) sb.check_result(out_data);
      if (in_valid && in_ready) sb.note_input(in_data);
      if (cfg_valid && cfg_ready) sb.set_register(cfg_index, cfg_data);
    end
  end

  initial begin
    int stall;
    out_ready <= 1'b0;
    do @(posedge clk); while (!rst_n);
    forever begin
      if (urandom_toggle()) rx_burst = !rx_burst;
      stall = rx_burst ? 0 : $urandom_range(0, 6);
      if (hold_request) begin
        hold_request = 1'b0;
        stall = 200;
      end
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
    end
  end

  function automatic in_item_t make_item(action_t a, int l, int r);
    in_item_t it;
    it.action     = a;
    it.rate_left  = l[15:0];
    it.rate_right = r[15:0];
    return it;
  endfunction

  function automatic logic signed [RateW-1:0] random_rate();
    case ($urandom_range(0, 4))
      0: begin
        case ($urandom_range(0, 4))
          0: return 16'sh8000;
          1: return 16'sh7FFF;
          2: return 16'sh0000;
          3: return -16'sd1;
          default: return 16'sd1;
        endcase
      end
      1, 2: return 16'($urandom_range(0, 128) - 64);
      3: return 16'($urandom_range(0, 8000) - 4000);
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic in_item_t random_item();
    int pick;
    pick = $urandom_range(0, 19);
    if (pick < 13) return make_item(ACT_TICK, $urandom, $urandom);
    if (pick < 17) return make_item(ACT_SET_RATES, random_rate(), random_rate());
    if (pick < 19) return make_item(ACT_STOP, $urandom, $urandom);
    return make_item(ACT_CLEAR_POS, $urandom, $urandom);
  endfunction

  task automatic send_item(in_item_t it);
    int gap;
    if (urandom_toggle()) tx_burst = !tx_burst;
    gap = tx_burst ? 0 : $urandom_range(0, 6);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic wait_for_results();
    in_valid <= 1'b0;
    do @(posedge clk); while (sb.pending() != 0);
    repeat (3) @(posedge clk);
  endtask

  task automatic write_reg(cfg_index_t idx, logic [CfgDataW-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic configure(logic [CfgDataW-1:0] freq, logic [CfgDataW-1:0] rate_cap,
                           logic [CfgDataW-1:0] inv_l, logic [CfgDataW-1:0] inv_r);
    write_reg(CFG_TICK_FREQUENCY, freq);
    write_reg(CFG_MAX_RATE, rate_cap);
    write_reg(CFG_INVERT_LEFT, inv_l);
    write_reg(CFG_INVERT_RIGHT, inv_r);
  endtask

  function automatic logic [CfgDataW-1:0] pick_tick_freq(int ph);
    case (ph)
      0: return 20'd1;
      1: return 20'd0;
      2: return 20'hFFFFF;
      default: return ($urandom_range(0, 4) == 0) ? 20'($urandom_range(200, 60000))
                                                  : 20'($urandom_range(2, 150));
    endcase
  endfunction

  function automatic logic [CfgDataW-1:0] pick_max_rate(int ph);
    case (ph)
      0: return 20'd32767;
      1: return 20'd0;
      2: return 20'd32767;
      4: return 20'hFFFFF;
      default: return ($urandom_range(0, 3) == 0) ? 20'($urandom)
                                                  : 20'($urandom_range(1, 400));
    endcase
  endfunction

  initial begin
    int ph;
    int n;
    rst_n     <= 1'b0;
    in_valid  <= 1'b0;
    in_data   <= '0;
    cfg_valid <= 1'b0;
    cfg_index <= CFG_TICK_FREQUENCY;
    cfg_data  <= '0;
    tx_burst = 1'b0;
    rx_burst = 1'b0;
    hold_request = 1'b0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset configuration: clamping of both rate extremes, zero rate, stop and clear.
    send_item(make_item(ACT_SET_RATES, 32767, -32768));
    repeat (8) send_item(make_item(ACT_TICK, 0, 0));
    send_item(make_item(ACT_SET_RATES, 0, 0));
    send_item(make_item(ACT_TICK, -1, -1));
    send_item(make_item(ACT_STOP, 0, 0));
    send_item(make_item(ACT_CLEAR_POS, 0, 0));

    // A tick frequency of zero behaves as one, so every magnitude clamps to zero.
    wait_for_results();
    configure(20'd0, 20'd32767, 20'd0, 20'd1);
    send_item(make_item(ACT_SET_RATES, -32768, 5));
    send_item(make_item(ACT_TICK, 0, 0));

    // A zero rate cap forces forward direction for negative rates.
    wait_for_results();
    configure(20'd3, 20'd0, 20'd1, 20'd1);
    send_item(make_item(ACT_SET_RATES, -7, -1));
    send_item(make_item(ACT_TICK, 0, 0));

    // Lowering the tick frequency while the accumulators hold large values.
    wait_for_results();
    configure(20'hFFFFF, 20'd32767, 20'd0, 20'd0);
    send_item(make_item(ACT_SET_RATES, 32767, -32767));
    repeat (2) send_item(make_item(ACT_TICK, 0, 0));
    wait_for_results();
    write_reg(CFG_TICK_FREQUENCY, 20'd5);
    repeat (3) send_item(make_item(ACT_TICK, 0, 0));
    send_item(make_item(ACT_STOP, 0, 0));
    send_item(make_item(ACT_TICK, 0, 0));
    send_item(make_item(ACT_CLEAR_POS, 0, 0));

    for (ph = 0; ph < 10; ph++) begin
      wait_for_results();
      if (ph % 2 == 0)
        configure(pick_tick_freq(ph), pick_max_rate(ph),
                  20'($urandom_range(0, 1)), 20'($urandom_range(0, 1)));
      else
        configure(pick_tick_freq(ph), pick_max_rate(ph), 20'($urandom), 20'($urandom));
      if (ph == 3) begin
        hold_request = 1'b1;
        tx_burst = 1'b1;
      end
      send_item(make_item(ACT_SET_RATES, random_rate(), random_rate()));
      for (n = 0; n < 52; n++) send_item(random_item());
    end

    wait_for_results();
    repeat (5) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end
endmodule
